### rtl/core/qvt_pkg.sv
// shared types, codes and constants of the action-value table
package qvt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_BEST   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic signed [31:0] BEST_FLOOR = -32'sd65470464;

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         mv;
        logic [7:0]         y;
        logic [7:0]         x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic key_hit;
        logic cell_hit;
        logic greater;
    } cmp_t;

endpackage

### rtl/core/qvt_mem.sv
// entry store: one write port and one registered read port
module qvt_mem #(
    parameter int DEPTH = qvt_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [qvt_pkg::ENTRY_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [qvt_pkg::ENTRY_W-1:0] rd_data
);

    logic [qvt_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [qvt_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/qvt_cmp.sv
// shared compare unit: key match, cell match and value ordering of one entry
module qvt_cmp (
    input  qvt_pkg::entry_t    entry,
    input  logic [7:0]         x,
    input  logic [7:0]         y,
    input  logic [7:0]         mv,
    input  logic signed [31:0] best,
    output qvt_pkg::cmp_t      res
);

    logic cell_eq;

    assign cell_eq      = (entry.x == x) && (entry.y == y);
    assign res.cell_hit = cell_eq;
    assign res.key_hit  = cell_eq && (entry.mv == mv);
    assign res.greater  = entry.value > best;

endmodule

### rtl/core/q_value_table.sv
// action-value table top level: request sequencer, entry store and compare unit
//
// Each request beat scans every stored entry in insertion order through one
// memory read port, one entry per cycle, then writes for an insert or update and
// presents its result. s_tready is low from accept to result, and stays low
// while an earlier result still waits on the m_ side. The next request is taken
// while a result still waits on the m_ side. After reset the table is empty and
// ready at once.
module q_value_table #(
    parameter int TABLE_DEPTH = qvt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // x[7:0], y[15:8], move[23:16], value_in[55:24]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_out[31:0], best_move[39:32]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic [1:0]         act_reg, act_next;
    logic [7:0]         x_reg, x_next;
    logic [7:0]         y_reg, y_next;
    logic [7:0]         mv_reg, mv_next;
    logic signed [31:0] val_reg, val_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    logic signed [31:0] hit_val_reg, hit_val_next;
    logic               found_reg, found_next;
    logic signed [31:0] best_val_reg, best_val_next;
    logic [7:0]         best_mv_reg, best_mv_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        vout_reg, vout_next;
    logic [7:0]         bmove_reg, bmove_next;

    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wr_addr;
    qvt_pkg::entry_t               wr_entry, rd_entry;
    logic [qvt_pkg::ENTRY_W-1:0]   rd_data;
    qvt_pkg::cmp_t                 cmp;
    logic                          out_free, table_full;

    qvt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_entry = rd_data;

    qvt_cmp u_cmp (
        .entry (rd_entry),
        .x     (x_reg),
        .y     (y_reg),
        .mv    (mv_reg),
        .best  (best_val_reg),
        .res   (cmp)
    );

    assign out_free   = !m_tvalid_reg || m_tready;
    assign table_full = count_reg >= CW'(TABLE_DEPTH);
    assign s_tready   = (state_reg == S_IDLE);
    assign rd_en      = (state_reg == S_SCAN) && (issue_reg < count_reg);

    assign wr_entry.x     = x_reg;
    assign wr_entry.y     = y_reg;
    assign wr_entry.mv    = mv_reg;
    assign wr_entry.value = val_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        act_next      = act_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        mv_next       = mv_reg;
        val_next      = val_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_val_next  = hit_val_reg;
        found_next    = found_reg;
        best_val_next = best_val_reg;
        best_mv_next  = best_mv_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        bmove_next    = bmove_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next      = s_tuser;
                    x_next        = s_tdata[7:0];
                    y_next        = s_tdata[15:8];
                    mv_next       = s_tdata[23:16];
                    val_next      = s_tdata[55:24];
                    issue_next    = '0;
                    pend_next     = 1'b0;
                    hit_next      = 1'b0;
                    found_next    = 1'b0;
                    best_val_next = qvt_pkg::BEST_FLOOR;
                    best_mv_next  = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // entry read last cycle is checked while the next one is read
                if (pend_reg) begin
                    if (!hit_reg && cmp.key_hit) begin
                        hit_next     = 1'b1;
                        hit_idx_next = pend_idx_reg;
                        hit_val_next = rd_entry.value;
                    end
                    if (cmp.cell_hit && cmp.greater) begin
                        found_next    = 1'b1;
                        best_val_next = rd_entry.value;
                        best_mv_next  = rd_entry.mv;
                    end
                end
                if (rd_en) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[AW-1:0];
                    issue_next    = CW'(issue_reg + 1'b1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    status_next   = qvt_pkg::ST_MISS;
                    vout_next     = '0;
                    bmove_next    = '0;
                    case (act_reg)
                        qvt_pkg::ACT_INSERT: begin
                            if (hit_reg) begin
                                status_next = qvt_pkg::ST_MISS;
                            end else if (table_full) begin
                                status_next = qvt_pkg::ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[AW-1:0];
                                count_next  = CW'(count_reg + 1'b1);
                                status_next = qvt_pkg::ST_OK;
                            end
                        end
                        qvt_pkg::ACT_LOOKUP: begin
                            if (hit_reg) begin
                                status_next = qvt_pkg::ST_OK;
                                vout_next   = hit_val_reg;
                            end
                        end
                        qvt_pkg::ACT_UPDATE: begin
                            if (hit_reg) begin
                                wr_en       = 1'b1;
                                wr_addr     = hit_idx_reg;
                                status_next = qvt_pkg::ST_OK;
                            end
                        end
                        default: begin
                            if (found_reg) begin
                                status_next = qvt_pkg::ST_OK;
                                vout_next   = best_val_reg;
                                bmove_next  = best_mv_reg;
                            end
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        act_reg      <= act_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        mv_reg       <= mv_next;
        val_reg      <= val_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        found_reg    <= found_next;
        best_val_reg <= best_val_next;
        best_mv_reg  <= best_mv_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
        bmove_reg    <= bmove_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {bmove_reg, vout_reg};
    assign m_tuser  = status_reg;

endmodule

### tb/qvt_checker.sv
// checker for the action-value table: watches both channels, predicts each reply, compares
module qvt_checker
    import qvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // x[7:0], y[15:8], move[23:16], value_in[55:24]
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // value_out[31:0], best_move[39:32]
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          fail_count,
    output int          pending
);

    localparam logic signed [31:0] VALUE_FLOOR = -32'sd999 * 32'sd65536;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [7:0]         best_move;
    } reply_t;

    entry_t      entries [TABLE_DEPTH];
    int unsigned entry_count = 0;
    reply_t      pending_replies [$];
    int          errs = 0;

    function automatic int find_entry(input logic [7:0] cx, input logic [7:0] cy,
                                      input logic [7:0] mv);
        for (int i = 0; i < entry_count; i++) begin
            if (entries[i].x == cx && entries[i].y == cy && entries[i].mv == mv)
                return i;
        end
        return -1;
    endfunction

    function automatic reply_t table_access(input logic [1:0] act, input logic [7:0] cx,
                                            input logic [7:0] cy, input logic [7:0] mv,
                                            input logic signed [31:0] v);
        reply_t             r;
        int                 idx;
        logic signed [31:0] top_val;
        r = '{status: ST_MISS, value: '0, best_move: '0};
        case (act)
            ACT_INSERT: begin
                if (find_entry(cx, cy, mv) >= 0) begin
                    r.status = ST_MISS;
                end else if (entry_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    entries[entry_count] = '{value: v, mv: mv, y: cy, x: cx};
                    entry_count++;
                    r.status = ST_OK;
                end
            end
            ACT_LOOKUP: begin
                idx = find_entry(cx, cy, mv);
                if (idx >= 0) begin
                    r.status = ST_OK;
                    r.value = entries[idx].value;
                end
            end
            ACT_UPDATE: begin
                idx = find_entry(cx, cy, mv);
                if (idx >= 0) begin
                    entries[idx].value = v;
                    r.status = ST_OK;
                end
            end
            ACT_BEST: begin
                top_val = VALUE_FLOOR;
                for (int i = 0; i < entry_count; i++) begin
                    if (entries[i].x == cx && entries[i].y == cy &&
                        $signed(entries[i].value) > top_val) begin
                        top_val = entries[i].value;
                        r.best_move = entries[i].mv;
                        r.status = ST_OK;
                    end
                end
                if (r.status == ST_OK)
                    r.value = top_val;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            entry_count = 0;
            pending_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{status: m_tuser, value: m_tdata[31:0], best_move: m_tdata[39:32]};
                if (pending_replies.size() == 0) begin
                    $error("result beat with none pending: status %0d value %0d best_move %0d",
                           got.status, $signed(got.value), got.best_move);
                    errs++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.value !== want.value) begin
                        $error("value_out expected %0d got %0d",
                               $signed(want.value), $signed(got.value));
                        errs++;
                    end
                    if (got.best_move !== want.best_move) begin
                        $error("best_move expected %0d got %0d", want.best_move, got.best_move);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = table_access(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                    s_tdata[23:16], s_tdata[55:24]);
                pending_replies = {pending_replies, want};
            end
        end
        fail_count <= errs;
        pending <= pending_replies.size();
    end

endmodule

### tb/tb_top.sv
// testbench top for the action-value table: clock, reset, request stimulus and verdict
module tb_top;
    import qvt_pkg::*;

    localparam int DRAIN_CYCLES = TABLE_DEPTH_DEFAULT + 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // x[7:0], y[15:8], move[23:16], value_in[55:24]
    logic [1:0]  s_tuser = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // value_out[31:0], best_move[39:32]
    logic [1:0]  m_tuser;        // status[1:0]
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    q_value_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    qvt_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return 8'($urandom_range(0, 3));
        else if (sel == 7)
            return 8'd255;
        else if (sel == 8)
            return 8'($urandom_range(16, 33));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_move();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return 8'($urandom_range(0, 15));
        else if (sel == 8)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return BEST_FLOOR;
            3: return 32'h0;
            4: return BEST_FLOOR - 32'sd1;
            5: return BEST_FLOOR + 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] act, input logic [7:0] cx, input logic [7:0] cy,
                            input logic [7:0] mv, input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, mv, cy, cx};
        s_tuser <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_item();
        int         sel;
        logic [1:0] act;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            act = ACT_INSERT;
        else if (sel < 55)
            act = ACT_LOOKUP;
        else if (sel < 75)
            act = ACT_UPDATE;
        else
            act = ACT_BEST;
        send_req(act, pick_coord(), pick_coord(), pick_move(), pick_value());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 49;

        // empty table
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd0, 32'h0);
        send_req(ACT_LOOKUP, 8'd0, 8'd0, 8'd0, 32'h0);
        send_req(ACT_UPDATE, 8'd0, 8'd0, 8'd0, 32'd5);
        // duplicate insert, values at or below the floor
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd0, 32'h8000_0000);
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd0, 32'd7);
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd255, 32'hffff_ffff);
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd1, BEST_FLOOR);
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd0, 32'h0);
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd2, BEST_FLOOR + 32'sd1);
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd0, 32'h0);
        // tie on the maximum goes to the earlier entry
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd3, 32'h7fff_ffff);
        send_req(ACT_INSERT, 8'd0, 8'd0, 8'd4, 32'h7fff_ffff);
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd0, 32'h0);
        send_req(ACT_UPDATE, 8'd0, 8'd0, 8'd3, 32'h8000_0000);
        send_req(ACT_BEST,   8'd0, 8'd0, 8'd0, 32'h0);
        // top corner keys
        send_req(ACT_INSERT, 8'd255, 8'd255, 8'd255, 32'hffff_ffff);
        send_req(ACT_LOOKUP, 8'd255, 8'd255, 8'd255, 32'h0);
        send_req(ACT_UPDATE, 8'd255, 8'd255, 8'd255, 32'h0);
        send_req(ACT_LOOKUP, 8'd255, 8'd255, 8'd255, 32'hffff_ffff);
        send_req(ACT_LOOKUP, 8'd255, 8'd255, 8'd254, 32'h0);
        send_req(ACT_INSERT, 8'd255, 8'd0, 8'd128, 32'h5555_5555);
        send_req(ACT_BEST,   8'd255, 8'd0, 8'd0, 32'h0);
        send_req(ACT_BEST,   8'd0, 8'd255, 8'd0, 32'h0);
        send_req(ACT_LOOKUP, 8'd0, 8'd0, 8'd0, 32'h0);

        repeat (400) send_random_item();

        send_idle_pct = 49;
        recv_idle_pct = 36;
        // distinct new keys, enough to fill the table
        for (int k = 0; k < 280; k++)
            send_req(ACT_INSERT, 8'(16 + k / 16), 8'(k % 16), 8'($urandom_range(0, 15)),
                     pick_value());
        repeat (250) send_random_item();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (300) send_random_item();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/core/qvt_pkg.sv
rtl/core/qvt_mem.sv
rtl/core/qvt_cmp.sv
rtl/core/q_value_table.sv
tb/qvt_checker.sv
tb/tb_top.sv
